// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top level RTL file of the interval set block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error(msg);

// Antecedent in one cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- rtl/isud_pkg.sv -----
// Package with the shared constants of the interval set block.
`timescale 1ns / 1ps
package isud_pkg;
	// Default parameter values.
	localparam int ID_WIDTH_DEF      = 20;
	localparam int MAX_INTERVALS_DEF = 16;

	// Operation codes carried in the input tuser.
	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_QUERY  = 2'd1;
	localparam logic [1:0] FUNC_DIFF   = 2'd2;
	localparam logic [1:0] FUNC_CLEAR  = 2'd3;

	// Width of one stored interval entry, start above end.
	function automatic int entry_width(input int id_width);
		return 2 * id_width;
	endfunction
endpackage

// ----- rtl/isud_mem.sv -----
// Interval table memory: one write port and one registered read port.
`timescale 1ns / 1ps
module isud_mem #(
	parameter int ID_WIDTH      = isud_pkg::ID_WIDTH_DEF,
	parameter int MAX_INTERVALS = isud_pkg::MAX_INTERVALS_DEF
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [$clog2(MAX_INTERVALS)-1:0]            waddr,
	input  logic [isud_pkg::entry_width(ID_WIDTH)-1:0]  wdata,
	input  logic                                        re,
	input  logic [$clog2(MAX_INTERVALS)-1:0]            raddr,
	output logic [isud_pkg::entry_width(ID_WIDTH)-1:0]  rdata
);
	import isud_pkg::*;

	localparam int EW = entry_width(ID_WIDTH);

	logic [EW-1:0] mem [MAX_INTERVALS];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; data holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ----- rtl/interval_set_union_difference.sv -----
// Top level of the sorted interval set with insert, query, diff and clear.
`timescale 1ns / 1ps
// Usage:
// The slave stream takes one command per transaction: tuser holds func and
// peer_empty, tlast holds peer_last, tdata holds range_low, range_high and
// query_id. The master stream returns results; tlast marks the last result
// of a command, tuser holds out_valid, is_member and overflow, and tdata
// holds out_low, out_high and held_count.
// A small sequencer drives one compare and add unit over the interval table,
// one table entry at a time (registered memory read, then evaluate).
// A query scans the table once and a clear scans nothing; a diff step
// scans once for one peer gap (twice for a final step with two gaps),
// and an insert scans, moves entries as needed, then rescans to recount
// held ids. s_tready is high only while the sequencer is idle.
// Reset empties the set and the diff state; the table contents themselves
// are not cleared. A stalled receiver holds the result in the output
// register and the sequencer waits before it produces another result.
module interval_set_union_difference #(
	parameter int ID_WIDTH      = isud_pkg::ID_WIDTH_DEF,
	parameter int MAX_INTERVALS = isud_pkg::MAX_INTERVALS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// Fields from bit 0: range_low, range_high, query_id, zero fill.
	input  logic [((3*ID_WIDTH+7)/8)*8-1:0]     s_tdata,
	// Fields from bit 0: func (2 bits), peer_empty.
	input  logic [2:0]                          s_tuser,
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// Fields from bit 0: out_low, out_high, held_count, zero fill.
	output logic [((3*ID_WIDTH+7)/8)*8-1:0]     m_tdata,
	// Fields from bit 0: out_valid, is_member, overflow.
	output logic [2:0]                          m_tuser,
	output logic                                m_tlast
);
	import isud_pkg::*;

	localparam int W  = ID_WIDTH;
	localparam int AW = $clog2(MAX_INTERVALS);
	localparam int CW = $clog2(MAX_INTERVALS + 1);
	localparam int DW = ((3*ID_WIDTH+7)/8)*8;
	localparam int EW = entry_width(ID_WIDTH);
	localparam logic [CW-1:0] MaxCount = CW'(MAX_INTERVALS);
	localparam logic [W:0]    IdMax    = {1'b0, {W{1'b1}}};

	// Sequencer states.
	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_RD    = 4'd1;
	localparam logic [3:0] S_EV    = 4'd2;
	localparam logic [3:0] S_MWR   = 4'd3;
	localparam logic [3:0] S_DNRD  = 4'd4;
	localparam logic [3:0] S_DNWR  = 4'd5;
	localparam logic [3:0] S_UPRD  = 4'd6;
	localparam logic [3:0] S_UPWR  = 4'd7;
	localparam logic [3:0] S_INSWR = 4'd8;
	localparam logic [3:0] S_FIN   = 4'd9;

	// Scan modes.
	localparam logic [1:0] MODE_INS  = 2'd0;
	localparam logic [1:0] MODE_QRY  = 2'd1;
	localparam logic [1:0] MODE_DIFF = 2'd2;
	localparam logic [1:0] MODE_SUM  = 2'd3;

	logic [3:0]    state_q;
	logic [1:0]    mode_q;
	logic [W-1:0]  a_q, b_q, qid_q;
	logic [W:0]    g0_q, g1_q;
	logic          more_q;
	logic [CW-1:0] i_q, count_q, p_q;
	logic [W-1:0]  held_q, prev_q, acc_q, mstart_q, mend_q;
	logic          found_q, pfound_q, member_q, ovf_q;
	logic [AW-1:0] first_q, lastm_q;
	logic          pend_v_q;
	logic [W-1:0]  pend_lo_q, pend_hi_q;
	logic [W-1:0]  o_lo_q, o_hi_q, o_held_q;
	logic          o_valid_q, o_last_q, o_member_q, o_ovf_q, m_tvalid_q;

	logic          mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [EW-1:0] mem_wdata, mem_rdata;

	logic [W-1:0]  in_lo, in_hi, in_qid, rs, rend;
	logic [1:0]    in_func;
	logic [W:0]    ilo, ihi;
	logic          hit, overlap, slot_free, accept, emit;
	logic [AW-1:0] removed;

	assign in_lo   = s_tdata[W-1:0];
	assign in_hi   = s_tdata[2*W-1:W];
	assign in_qid  = s_tdata[3*W-1:2*W];
	assign in_func = s_tuser[1:0];

	assign rs   = mem_rdata[EW-1:W];
	assign rend = mem_rdata[W-1:0];

	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign slot_free = !m_tvalid_q || m_tready;
	assign removed   = lastm_q - first_q;

	// A result enters the output register at the final step or when a held range is pushed out.
	assign emit = slot_free && ((state_q == S_FIN) ||
	              (state_q == S_EV && mode_q == MODE_DIFF && hit && pend_v_q));

	// Shared compare unit: gap intersection and insert overlap test.
	always_comb begin
		ilo     = ({1'b0, rs} > g0_q) ? {1'b0, rs} : g0_q;
		ihi     = ({1'b0, rend} < g1_q) ? {1'b0, rend} : g1_q;
		hit     = (ilo <= ihi);
		overlap = ({1'b0, rs} <= ({1'b0, b_q} + 1'b1)) &&
		          (({1'b0, rend} + 1'b1) >= {1'b0, a_q});
	end

	// Table port control.
	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = i_q[AW-1:0];
		mem_we    = 1'b0;
		mem_waddr = i_q[AW-1:0];
		mem_wdata = mem_rdata;
		case (state_q)
			S_RD, S_DNRD: begin
				mem_re = (i_q != count_q);
			end
			S_UPRD: begin
				mem_re    = (i_q != p_q);
				mem_raddr = AW'(i_q - 1'b1);
			end
			S_MWR: begin
				mem_we    = 1'b1;
				mem_waddr = first_q;
				mem_wdata = {((mstart_q < a_q) ? mstart_q : a_q),
				             ((mend_q > b_q) ? mend_q : b_q)};
			end
			S_DNWR: begin
				mem_we    = 1'b1;
				mem_waddr = i_q[AW-1:0] - removed;
			end
			S_UPWR: begin
				mem_we = 1'b1;
			end
			S_INSWR: begin
				mem_we    = 1'b1;
				mem_waddr = p_q[AW-1:0];
				mem_wdata = {a_q, b_q};
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	isud_mem #(
		.ID_WIDTH      (ID_WIDTH),
		.MAX_INTERVALS (MAX_INTERVALS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Output valid flag: set on a new result, cleared when the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Sequencer and result path.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			held_q     <= '0;
			prev_q     <= '0;
			pend_v_q   <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						a_q      <= in_lo;
						b_q      <= in_hi;
						qid_q    <= in_qid;
						i_q      <= '0;
						p_q      <= count_q;
						found_q  <= 1'b0;
						pfound_q <= 1'b0;
						member_q <= 1'b0;
						ovf_q    <= 1'b0;
						pend_v_q <= 1'b0;
						more_q   <= 1'b0;
						case (in_func)
							FUNC_INSERT: begin
								mode_q <= MODE_INS;
								if (in_lo == '0 || in_lo > in_hi) begin
									state_q <= S_FIN;
								end else begin
									state_q <= S_RD;
								end
							end
							FUNC_QUERY: begin
								mode_q  <= MODE_QRY;
								state_q <= S_RD;
							end
							FUNC_DIFF: begin
								mode_q <= MODE_DIFF;
								if (s_tuser[2]) begin
									g0_q    <= (W+1)'(1);
									g1_q    <= IdMax;
									prev_q  <= '0;
									state_q <= S_RD;
								end else begin
									prev_q <= s_tlast ? '0 : in_hi;
									if (in_lo != '0) begin
										g0_q    <= {1'b0, prev_q} + 1'b1;
										g1_q    <= {1'b0, in_lo} - 1'b1;
										more_q  <= s_tlast;
										state_q <= S_RD;
									end else if (s_tlast) begin
										g0_q    <= {1'b0, in_hi} + 1'b1;
										g1_q    <= IdMax;
										state_q <= S_RD;
									end else begin
										state_q <= S_FIN;
									end
								end
							end
							default: begin
								count_q <= '0;
								held_q  <= '0;
								prev_q  <= '0;
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_RD: begin
					if (i_q != count_q) begin
						state_q <= S_EV;
					end else begin
						case (mode_q)
							MODE_INS: begin
								if (found_q) begin
									state_q <= S_MWR;
								end else if (count_q >= MaxCount) begin
									ovf_q   <= 1'b1;
									state_q <= S_FIN;
								end else begin
									state_q <= S_UPRD;
								end
							end
							MODE_DIFF: begin
								if (more_q) begin
									g0_q   <= {1'b0, b_q} + 1'b1;
									g1_q   <= IdMax;
									more_q <= 1'b0;
									i_q    <= '0;
								end else begin
									state_q <= S_FIN;
								end
							end
							MODE_SUM: begin
								held_q  <= acc_q;
								state_q <= S_FIN;
							end
							default: begin
								state_q <= S_FIN;
							end
						endcase
					end
				end
				S_EV: begin
					case (mode_q)
						MODE_INS: begin
							if (overlap) begin
								if (!found_q) begin
									found_q  <= 1'b1;
									first_q  <= i_q[AW-1:0];
									mstart_q <= rs;
								end
								lastm_q <= i_q[AW-1:0];
								mend_q  <= rend;
							end
							if (!pfound_q && rs > b_q) begin
								pfound_q <= 1'b1;
								p_q      <= i_q;
							end
							i_q     <= i_q + 1'b1;
							state_q <= S_RD;
						end
						MODE_QRY: begin
							if (qid_q >= rs && qid_q <= rend) begin
								member_q <= 1'b1;
							end
							i_q     <= i_q + 1'b1;
							state_q <= S_RD;
						end
						MODE_DIFF: begin
							// A new range pushes the held one out unless the output is busy.
							if (!hit) begin
								i_q     <= i_q + 1'b1;
								state_q <= S_RD;
							end else if (!pend_v_q || slot_free) begin
								if (pend_v_q) begin
									o_lo_q     <= pend_lo_q;
									o_hi_q     <= pend_hi_q;
									o_valid_q  <= 1'b1;
									o_last_q   <= 1'b0;
									o_member_q <= 1'b0;
									o_ovf_q    <= 1'b0;
									o_held_q   <= held_q;
								end
								pend_v_q  <= 1'b1;
								pend_lo_q <= ilo[W-1:0];
								pend_hi_q <= ihi[W-1:0];
								i_q       <= i_q + 1'b1;
								state_q   <= S_RD;
							end
						end
						default: begin
							acc_q   <= acc_q + (rend - rs + 1'b1);
							i_q     <= i_q + 1'b1;
							state_q <= S_RD;
						end
					endcase
				end
				S_MWR: begin
					i_q     <= CW'(lastm_q) + 1'b1;
					state_q <= S_DNRD;
				end
				S_DNRD: begin
					if (i_q == count_q) begin
						count_q <= count_q - CW'(removed);
						mode_q  <= MODE_SUM;
						acc_q   <= '0;
						i_q     <= '0;
						state_q <= S_RD;
					end else begin
						state_q <= S_DNWR;
					end
				end
				S_DNWR: begin
					i_q     <= i_q + 1'b1;
					state_q <= S_DNRD;
				end
				S_UPRD: begin
					if (i_q == p_q) begin
						state_q <= S_INSWR;
					end else begin
						state_q <= S_UPWR;
					end
				end
				S_UPWR: begin
					i_q     <= i_q - 1'b1;
					state_q <= S_UPRD;
				end
				S_INSWR: begin
					count_q <= count_q + 1'b1;
					mode_q  <= MODE_SUM;
					acc_q   <= '0;
					i_q     <= '0;
					state_q <= S_RD;
				end
				S_FIN: begin
					// Final result of the command, carrying the held range if any.
					if (slot_free) begin
						o_lo_q     <= pend_v_q ? pend_lo_q : '0;
						o_hi_q     <= pend_v_q ? pend_hi_q : '0;
						o_valid_q  <= pend_v_q;
						o_last_q   <= 1'b1;
						o_member_q <= member_q;
						o_ovf_q    <= ovf_q;
						o_held_q   <= held_q;
						pend_v_q   <= 1'b0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = DW'({o_held_q, o_hi_q, o_lo_q});
	assign m_tuser  = {o_ovf_q, o_member_q, o_valid_q};
	assign m_tlast  = o_last_q;

`include "assert_macros.svh"

	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= MaxCount, "interval count above table size")
	`ASSERT_IMPLIES(a_idle_no_pend, clk, arst_n, s_tready, !pend_v_q, "held range left while idle")
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, !s_tready, "ready stayed high after accept")
endmodule
